// ===== hw/rtl/stki_pkg.sv =====
// Shared types and codes for the sorted top-K table insert unit.
`timescale 1ns / 1ps

package stki_pkg;

  localparam int SCORE_W = 24;
  localparam int PLAY_W  = 20;
  localparam int NAME_W  = 64;
  localparam int LEN_W   = 4;
  localparam int IDX_W   = 4;
  localparam int POS_W   = 5;
  localparam int CNT_W   = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // one table entry, moves from cell to cell
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [PLAY_W-1:0]  playtime;
    logic [NAME_W-1:0]  name;
    logic [LEN_W-1:0]   name_length;
  } entry_t;

endpackage

// ===== hw/rtl/stki_cell.sv =====
// One table cell: holds an entry, compares it to the new one, shifts on insert.
`timescale 1ns / 1ps

module stki_cell (
  input  logic            clk,
  input  logic            ins_en,
  input  logic            occupied,
  input  stki_pkg::entry_t new_entry,
  input  stki_pkg::entry_t prev_entry,
  input  logic            prev_after,
  output stki_pkg::entry_t entry,
  output logic            after,
  output logic            place
);

  stki_pkg::entry_t entry_r;

  // held entry ranks above or equal to the new one: new one goes after it
  always_comb begin
    after = occupied &&
            ((entry_r.score > new_entry.score) ||
             ((entry_r.score == new_entry.score) &&
              (entry_r.playtime <= new_entry.playtime)));
    place = !after && prev_after;
  end

  always_ff @(posedge clk) begin
    if (ins_en && !after) begin
      entry_r <= prev_after ? new_entry : prev_entry;
    end
  end

  assign entry = entry_r;

endmodule

// ===== hw/rtl/sorted_top_k_table_insert_unit.sv =====
// Top level of the sorted top-K table insert unit: cell chain plus result stage.
`timescale 1ns / 1ps

// Sorted top-K table. Entries are kept ranked by score (high first), then
// playtime (low first); a new entry lands after all equal entries, lower
// entries move down one cell and the last drops out. Every cell compares its
// entry against the incoming one in parallel, so an insert or a read is done
// in one compare-and-shift pass: a command is taken at any clock edge with
// start high and busy low, and its result transaction appears on the out_ ports
// in the next cycle, flagged by out_valid for a single cycle. The receiver cannot
// stall, so one command per clock is sustained; the limit is the single
// compare-and-shift pass through the cell chain. busy is high only during
// reset and until the next clock edge. Names shorter than eight characters have
// their unused bytes stored as zero; lengths above NAME_CHARS are clamped.
// Rank position is reported as TABLE_DEPTH for reads and for ignored or
// rejected inserts; position and entry_count are 5-bit fields and wrap for
// tables deeper than 31.
module sorted_top_k_table_insert_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int NAME_CHARS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [stki_pkg::SCORE_W-1:0]  in_score,
  input  logic [stki_pkg::PLAY_W-1:0]   in_playtime,
  input  logic [stki_pkg::NAME_W-1:0]   in_name,
  input  logic [stki_pkg::LEN_W-1:0]    in_name_length,
  input  logic [stki_pkg::IDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  output logic                          out_accepted,
  output logic [stki_pkg::POS_W-1:0]    out_position,
  output logic [stki_pkg::CNT_W-1:0]    out_entry_count,
  output logic                          out_read_valid,
  output logic [stki_pkg::SCORE_W-1:0]  out_read_score,
  output logic [stki_pkg::PLAY_W-1:0]   out_read_playtime,
  output logic [stki_pkg::NAME_W-1:0]   out_read_name,
  output logic [stki_pkg::LEN_W-1:0]    out_read_name_length
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // control
  logic          busy_r;
  logic          out_valid_r;
  logic [CW-1:0] count_r, count_nxt;

  // result stage payload
  logic                   acc_r;
  logic [TABLE_DEPTH-1:0] place_r;
  logic [CW-1:0]          cnt_out_r;
  logic                   rd_valid_r;
  stki_pkg::entry_t       rd_entry_r;

  // command decode
  logic                   take;
  logic                   ins_en;
  logic                   accept;
  logic [stki_pkg::LEN_W-1:0]  len_eff;
  logic [stki_pkg::NAME_W-1:0] name_m;
  stki_pkg::entry_t       new_entry;

  // chain
  stki_pkg::entry_t       cell_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] after;
  logic [TABLE_DEPTH-1:0] place;

  // read port
  logic                   rd_ok;
  logic [IW-1:0]          rd_idx;
  stki_pkg::entry_t       rd_entry;

  logic [CW-1:0]          pos;

  assign take = start && !busy_r;

  // clamp length, zero the bytes past it
  always_comb begin
    len_eff = in_name_length;
    if (in_name_length > stki_pkg::LEN_W'(NAME_CHARS)) begin
      len_eff = stki_pkg::LEN_W'(NAME_CHARS);
    end
    for (int b = 0; b < 8; b++) begin
      name_m[8*b +: 8] = (stki_pkg::LEN_W'(b) < len_eff) ? in_name[8*b +: 8] : 8'h00;
    end
    new_entry.score       = in_score;
    new_entry.playtime    = in_playtime;
    new_entry.name        = name_m;
    new_entry.name_length = len_eff;
  end

  // empty name is ignored; all cells "after" means the table is full and
  // the new entry ranks last, so nothing moves
  assign ins_en = take && (in_operation == stki_pkg::OP_INSERT) &&
                  (len_eff != '0);
  assign accept = ins_en && !after[TABLE_DEPTH-1];

  always_comb begin
    count_nxt = count_r;
    if (accept && (count_r != CW'(TABLE_DEPTH))) begin
      count_nxt = count_r + CW'(1);
    end
  end

  genvar k;
  generate
    for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
        stki_cell u_cell (
          .clk        (clk),
          .ins_en     (ins_en),
          .occupied   (CW'(k) < count_r),
          .new_entry  (new_entry),
          .prev_entry (new_entry),
          .prev_after (1'b1),
          .entry      (cell_q[k]),
          .after      (after[k]),
          .place      (place[k])
        );
      end else begin : g_body
        stki_cell u_cell (
          .clk        (clk),
          .ins_en     (ins_en),
          .occupied   (CW'(k) < count_r),
          .new_entry  (new_entry),
          .prev_entry (cell_q[k-1]),
          .prev_after (after[k-1]),
          .entry      (cell_q[k]),
          .after      (after[k]),
          .place      (place[k])
        );
      end
    end
  endgenerate

  // read: index below the count is always inside the table
  assign rd_ok    = (in_operation == stki_pkg::OP_READ) &&
                    (7'(in_read_index) < 7'(count_r));
  assign rd_idx   = IW'(in_read_index);
  assign rd_entry = cell_q[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= take;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r      <= accept;
      place_r    <= place;
      cnt_out_r  <= count_nxt;
      rd_valid_r <= rd_ok;
      rd_entry_r <= rd_ok ? rd_entry : '0;
    end
  end

  // one-hot insertion point to rank
  always_comb begin
    pos = CW'(TABLE_DEPTH);
    if (acc_r) begin
      pos = '0;
      for (int p = 0; p < TABLE_DEPTH; p++) begin
        if (place_r[p]) begin
          pos = pos | CW'(p);
        end
      end
    end
  end

  assign busy                 = busy_r;
  assign out_valid            = out_valid_r;
  assign out_accepted         = acc_r;
  assign out_position         = stki_pkg::POS_W'(pos);
  assign out_entry_count      = stki_pkg::CNT_W'(cnt_out_r);
  assign out_read_valid       = rd_valid_r;
  assign out_read_score       = rd_entry_r.score;
  assign out_read_playtime    = rd_entry_r.playtime;
  assign out_read_name        = rd_entry_r.name;
  assign out_read_name_length = rd_entry_r.name_length;

endmodule

// ===== hw/rtl/stki_checker.sv =====
// Port-level checks for the sorted top-K table insert unit, with its bind.
`timescale 1ns / 1ps

module stki_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_accepted,
  input logic                          out_read_valid,
  input logic [stki_pkg::SCORE_W-1:0]  out_read_score,
  input logic [stki_pkg::PLAY_W-1:0]   out_read_playtime,
  input logic [stki_pkg::NAME_W-1:0]   out_read_name,
  input logic [stki_pkg::LEN_W-1:0]    out_read_name_length
);

  // every accepted command gives a result transaction in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("no result after accepted command");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without command");

  // stored entries always have a name of one to eight characters
  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |->
      (out_read_name_length != '0) && (out_read_name_length <= 4'd8) && !out_accepted)
    else $error("bad read entry");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |->
      (out_read_score == '0) && (out_read_playtime == '0) &&
      (out_read_name == '0) && (out_read_name_length == '0))
    else $error("read fields not zero");

endmodule

bind sorted_top_k_table_insert_unit stki_checker u_stki_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_accepted         (out_accepted),
  .out_read_valid       (out_read_valid),
  .out_read_score       (out_read_score),
  .out_read_playtime    (out_read_playtime),
  .out_read_name        (out_read_name),
  .out_read_name_length (out_read_name_length)
);
